FILE: rtl/core/slm_pkg.sv
package slm_pkg;

    localparam int BLOCK_SAMPLES = 9;
    localparam int ADC_BITS      = 12;
    localparam int ADC_W         = 12;
    localparam int TICK_W        = 16;
    localparam int ELAPSED_W     = 20;
    localparam int UV_W          = 18;
    localparam int LEVEL_W       = 19;

    localparam longint unsigned ADC_MAX = (64'd1 << ADC_BITS) - 64'd1;
    localparam int COUNT_W = $clog2(BLOCK_SAMPLES);
    localparam int SUM_W   = $clog2(BLOCK_SAMPLES * ADC_MAX + 1);

    // floor(sum * 50 / BLOCK_SAMPLES) as one multiply by a rounded-up reciprocal
    localparam int UV_K = SUM_W + 4;
    localparam longint unsigned UV_MULT =
        ((64'd50 << UV_K) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES;
    localparam int MULT_W = $clog2(UV_MULT + 1);
    localparam int PROD_W = SUM_W + MULT_W;

    localparam longint unsigned FLOOR_UV = 64'd2512;
    localparam longint unsigned UV_MAX   = (64'd1 << UV_W) - 64'd1;

    localparam int Q_BITS    = 30;
    localparam int M_W       = Q_BITS + 1;
    localparam int FRAC_BITS = 16;
    localparam int E_W       = $clog2(UV_W);
    localparam int L_W       = E_W + FRAC_BITS;

    localparam longint unsigned DB_SCALE = 64'd394566;
    localparam int DB_SCALE_W = 19;
    localparam int LVL_SHIFT  = 24;
    localparam int LVL_PROD_W = L_W + DB_SCALE_W + 1;
    localparam longint unsigned REL_OFFSET = 64'd42 * 64'd256;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_SPL_DEFAULT = 2'd0,
        MODE_SPL         = 2'd1,
        MODE_REL         = 2'd2,
        MODE_VOLT        = 2'd3
    } unit_mode_t;

    typedef struct packed {
        logic                 valid;
        logic [SUM_W-1:0]     sum;
        logic [ELAPSED_W-1:0] ticks;
    } blk_t;

    typedef struct packed {
        logic                 valid;
        logic [UV_W-1:0]      uv;
        logic                 at_floor;
        logic [ELAPSED_W-1:0] ticks;
        logic [E_W-1:0]       e;
        logic [FRAC_BITS-1:0] frac;
        logic [M_W-1:0]       m;
    } log_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [UV_W-1:0]           uv;
        logic                      at_floor;
        logic [ELAPSED_W-1:0]      ticks;
    } result_t;

    function automatic longint unsigned log2_q16(input longint unsigned x);
        longint unsigned xv;
        longint unsigned e;
        longint unsigned frac;
        longint unsigned m;
        xv = (x == 64'd0) ? 64'd1 : x;
        e = 64'd0;
        frac = 64'd0;
        for (int i = 0; i < 31; i++)
        begin
            if ((xv >> (i + 1)) != 64'd0)
            begin
                e = 64'(i + 1);
            end
        end
        m = xv << (64'd30 - e);
        for (int i = 1; i <= 16; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | (64'd1 << (16 - i));
            end
        end
        return (e << 16) | frac;
    endfunction

    localparam longint unsigned L_FLOOR = log2_q16(FLOOR_UV);

endpackage

FILE: rtl/core/slm_accum.sv
module slm_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [slm_pkg::ADC_W-1:0]     adc_sample,
    input  logic [slm_pkg::TICK_W-1:0]    tick_count,
    input  logic                          out_take,
    output slm_pkg::blk_t                 blk
);

    logic [slm_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [slm_pkg::ELAPSED_W-1:0] tick_reg, tick_next;
    logic [slm_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [slm_pkg::CNT_W-1:0]     pending_reg, pending_next;
    slm_pkg::blk_t                 blk_reg, blk_next;

    logic                          accept;
    logic                          last;
    logic [slm_pkg::ADC_W-1:0]     sample_sat;
    logic [slm_pkg::SUM_W-1:0]     sum_add;
    logic [slm_pkg::ELAPSED_W-1:0] tick_add;

    assign last     = (count_reg == slm_pkg::COUNT_W'(slm_pkg::BLOCK_SAMPLES - 1));
    assign in_stall = last && (pending_reg == slm_pkg::CNT_W'(slm_pkg::FIFO_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (64'(adc_sample) > slm_pkg::ADC_MAX)
        begin
            sample_sat = slm_pkg::ADC_W'(slm_pkg::ADC_MAX);
        end
        else
        begin
            sample_sat = adc_sample;
        end
        sum_add  = sum_reg + slm_pkg::SUM_W'(sample_sat);
        tick_add = tick_reg + slm_pkg::ELAPSED_W'(tick_count);

        sum_next       = sum_reg;
        tick_next      = tick_reg;
        count_next     = count_reg;
        blk_next       = blk_reg;
        blk_next.valid = 1'b0;
        pending_next   = pending_reg;

        if (accept)
        begin
            if (last)
            begin
                blk_next.valid = 1'b1;
                blk_next.sum   = sum_add;
                blk_next.ticks = tick_add;
                sum_next       = '0;
                tick_next      = '0;
                count_next     = '0;
            end
            else
            begin
                sum_next   = sum_add;
                tick_next  = tick_add;
                count_next = count_reg + slm_pkg::COUNT_W'(1);
            end
        end

        // track blocks in flight or waiting in the result queue
        if ((accept && last) && !out_take)
        begin
            pending_next = pending_reg + slm_pkg::CNT_W'(1);
        end
        else if (!(accept && last) && out_take)
        begin
            pending_next = pending_reg - slm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            tick_reg      <= '0;
            count_reg     <= '0;
            pending_reg   <= '0;
            blk_reg.valid <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            tick_reg    <= tick_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            blk_reg     <= blk_next;
        end
    end

    assign blk = blk_reg;

endmodule

FILE: rtl/core/slm_volt.sv
module slm_volt (
    input  logic          clk,
    input  logic          rst_n,
    input  slm_pkg::blk_t blk,
    output slm_pkg::log_t norm
);

    typedef struct packed {
        logic                          valid;
        logic [slm_pkg::UV_W-1:0]      uv;
        logic                          at_floor;
        logic [slm_pkg::ELAPSED_W-1:0] ticks;
    } volt_t;

    volt_t                       volt_reg, volt_next;
    slm_pkg::log_t               norm_reg, norm_next;
    logic [slm_pkg::PROD_W-1:0]  prod;
    logic [slm_pkg::PROD_W-1:0]  uv_raw;
    logic [slm_pkg::E_W-1:0]     e;

    always_comb
    begin
        prod   = slm_pkg::PROD_W'(blk.sum) * slm_pkg::PROD_W'(slm_pkg::UV_MULT);
        uv_raw = prod >> slm_pkg::UV_K;

        volt_next.valid    = blk.valid;
        volt_next.ticks    = blk.ticks;
        volt_next.at_floor = 1'b0;
        if (64'(uv_raw) > slm_pkg::UV_MAX)
        begin
            volt_next.uv = slm_pkg::UV_W'(slm_pkg::UV_MAX);
        end
        else if (64'(uv_raw) < slm_pkg::FLOOR_UV)
        begin
            volt_next.uv       = slm_pkg::UV_W'(slm_pkg::FLOOR_UV);
            volt_next.at_floor = 1'b1;
        end
        else
        begin
            volt_next.uv = slm_pkg::UV_W'(uv_raw);
        end
    end

    always_comb
    begin
        e = '0;
        for (int i = 0; i < slm_pkg::UV_W; i++)
        begin
            if (volt_reg.uv[i])
            begin
                e = slm_pkg::E_W'(i);
            end
        end
        norm_next.valid    = volt_reg.valid;
        norm_next.uv       = volt_reg.uv;
        norm_next.at_floor = volt_reg.at_floor;
        norm_next.ticks    = volt_reg.ticks;
        norm_next.e        = e;
        norm_next.frac     = '0;
        // align the top set bit to the Q30 integer position
        norm_next.m        = slm_pkg::M_W'(volt_reg.uv) << (slm_pkg::Q_BITS - int'(e));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg.valid <= 1'b0;
            norm_reg.valid <= 1'b0;
        end
        else
        begin
            volt_reg <= volt_next;
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

endmodule

FILE: rtl/core/slm_sqr_stage.sv
module slm_sqr_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  slm_pkg::log_t stage_in,
    output slm_pkg::log_t stage_out
);

    slm_pkg::log_t                 stage_reg, stage_next;
    logic [2*slm_pkg::M_W-1:0]     sq;
    logic [slm_pkg::M_W:0]         t;

    always_comb
    begin
        sq = (2*slm_pkg::M_W)'(stage_in.m) * (2*slm_pkg::M_W)'(stage_in.m);
        t  = sq[2*slm_pkg::M_W-1:slm_pkg::Q_BITS];

        stage_next      = stage_in;
        stage_next.frac = {stage_in.frac[slm_pkg::FRAC_BITS-2:0], t[slm_pkg::M_W]};
        // halve once the square reaches two
        if (t[slm_pkg::M_W])
        begin
            stage_next.m = t[slm_pkg::M_W:1];
        end
        else
        begin
            stage_next.m = t[slm_pkg::M_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: rtl/core/slm_level.sv
module slm_level (
    input  slm_pkg::log_t      stage_in,
    input  slm_pkg::unit_mode_t mode,
    output logic               wr_en,
    output slm_pkg::result_t   result
);

    logic [slm_pkg::L_W-1:0]               log_val;
    logic [slm_pkg::L_W-1:0]               d;
    logic [slm_pkg::LVL_PROD_W-1:0]        prod;
    logic signed [slm_pkg::LEVEL_W-1:0]    db;

    always_comb
    begin
        log_val = {stage_in.e, stage_in.frac};
        d       = log_val - slm_pkg::L_W'(slm_pkg::L_FLOOR);
        prod    = slm_pkg::LVL_PROD_W'(d) * slm_pkg::LVL_PROD_W'(slm_pkg::DB_SCALE)
                + slm_pkg::LVL_PROD_W'(64'd1 << (slm_pkg::LVL_SHIFT - 1));
        db      = signed'(slm_pkg::LEVEL_W'(prod >> slm_pkg::LVL_SHIFT));

        unique case (mode)
            slm_pkg::MODE_REL:
            begin
                result.level = db - signed'(slm_pkg::LEVEL_W'(slm_pkg::REL_OFFSET));
            end
            slm_pkg::MODE_VOLT:
            begin
                result.level = signed'(slm_pkg::LEVEL_W'(stage_in.uv));
            end
            default:
            begin
                result.level = db;
            end
        endcase

        result.uv       = stage_in.uv;
        result.at_floor = stage_in.at_floor;
        result.ticks    = stage_in.ticks;
        wr_en           = stage_in.valid;
    end

endmodule

FILE: rtl/core/slm_out_fifo.sv
module slm_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  slm_pkg::result_t wr_data,
    input  logic             rd_en,
    output logic             rd_valid,
    output slm_pkg::result_t rd_data
);

    slm_pkg::result_t               mem [slm_pkg::FIFO_DEPTH];
    logic [slm_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [slm_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [slm_pkg::CNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == slm_pkg::PTR_W'(slm_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + slm_pkg::PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == slm_pkg::PTR_W'(slm_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + slm_pkg::PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + slm_pkg::CNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - slm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

endmodule

FILE: rtl/core/sound_level_meter_unit.sv
// A result passes the block, voltage and normalise registers and the squaring stages into the result queue.
// Throughput: one sample request per cycle while in_stall is low; one result per block of samples.
// The 16 log squarings run as a pipeline of one multiplier per stage.
// A four-entry result queue lets samples flow while a result waits.
// Reset (rst_n low, asynchronous) clears the sums, the count, unit_mode and
// all valid flags; no clearing pass follows.
module sound_level_meter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [slm_pkg::ADC_W-1:0]           adc_sample,
    input  logic [slm_pkg::TICK_W-1:0]          tick_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [slm_pkg::LEVEL_W-1:0]  level_value,
    output logic [slm_pkg::UV_W-1:0]            voltage_uv,
    output logic                                at_floor,
    output logic [slm_pkg::ELAPSED_W-1:0]       elapsed_ticks,
    input  logic                                unit_mode_write,
    input  logic [1:0]                          unit_mode
);

    slm_pkg::unit_mode_t unit_mode_reg;
    slm_pkg::blk_t       blk;
    slm_pkg::log_t       sqr_pipe [slm_pkg::FRAC_BITS+1];
    slm_pkg::result_t    level_result;
    slm_pkg::result_t    out_result;
    logic                level_wr;
    logic                out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg <= slm_pkg::MODE_SPL_DEFAULT;
        end
        else if (unit_mode_write)
        begin
            unit_mode_reg <= slm_pkg::unit_mode_t'(unit_mode);
        end
    end

    assign out_take = out_valid && !out_stall;

    slm_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .tick_count (tick_count),
        .out_take   (out_take),
        .blk        (blk)
    );

    slm_volt u_volt (
        .clk   (clk),
        .rst_n (rst_n),
        .blk   (blk),
        .norm  (sqr_pipe[0])
    );

    for (genvar g = 0; g < slm_pkg::FRAC_BITS; g++)
    begin : g_sqr
        slm_sqr_stage u_sqr (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (sqr_pipe[g]),
            .stage_out (sqr_pipe[g+1])
        );
    end

    slm_level u_level (
        .stage_in (sqr_pipe[slm_pkg::FRAC_BITS]),
        .mode     (unit_mode_reg),
        .wr_en    (level_wr),
        .result   (level_result)
    );

    slm_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (level_wr),
        .wr_data  (level_result),
        .rd_en    (out_take),
        .rd_valid (out_valid),
        .rd_data  (out_result)
    );

    assign level_value   = out_result.level;
    assign voltage_uv    = out_result.uv;
    assign at_floor      = out_result.at_floor;
    assign elapsed_ticks = out_result.ticks;

endmodule

FILE: rtl/core/slm_checker.sv
module slm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [slm_pkg::LEVEL_W-1:0]  level_value,
    input  logic [slm_pkg::UV_W-1:0]            voltage_uv,
    input  logic                                at_floor
);

    localparam logic [slm_pkg::UV_W-1:0] FLOOR = slm_pkg::UV_W'(slm_pkg::FLOOR_UV);
    localparam logic signed [slm_pkg::LEVEL_W-1:0] REL_FLOOR =
        -signed'(slm_pkg::LEVEL_W'(slm_pkg::REL_OFFSET));
    localparam logic signed [slm_pkg::LEVEL_W-1:0] VOLT_FLOOR =
        signed'(slm_pkg::LEVEL_W'(slm_pkg::FLOOR_UV));

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(level_value) && $stable(voltage_uv))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (voltage_uv >= FLOOR) && (!at_floor || voltage_uv == FLOOR))
    else $error("voltage below floor or floor flag mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_floor |->
            (level_value == '0) || (level_value == REL_FLOOR) || (level_value == VOLT_FLOOR))
    else $error("level at floor has wrong value");

    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result offered during reset");

endmodule

bind sound_level_meter_unit slm_checker u_slm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level_value (level_value),
    .voltage_uv  (voltage_uv),
    .at_floor    (at_floor)
);
